### rtl/wpd_pkg.sv
// Package for the windowed peak detector: item payload structs, command and
// status structs between controller and datapath, register index codes.
// No dependencies.
`default_nettype none

package wpd_pkg;

    localparam int SMP_W  = 12;   // sample and intensity width
    localparam int PIX_W  = 12;   // pixel index width
    localparam int THR_W  = 13;   // threshold register width
    localparam int DIST_W = 8;    // min_distance register width
    localparam int OFF_W  = DIST_W + 1;  // offset within a window of 2d+1
    localparam int CFG_W  = 13;   // widest configuration register
    localparam int CIDX_W = 1;    // configuration index width

    localparam logic [CIDX_W-1:0] CFG_THRESHOLD    = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MIN_DISTANCE = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 13'd1000;
    localparam logic [DIST_W-1:0] DIST_RESET = 8'd20;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             frame_start;
    } t_in;

    typedef struct packed {
        logic             is_peak;
        logic [PIX_W-1:0] peak_pixel;
        logic [SMP_W-1:0] peak_intensity;
        logic             frame_end;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // take the input item, store its sample
        logic rd_center;    // read the judged pixel from the window store
        logic load_center;  // capture the judged value, start the threshold test
        logic sweep;        // issue one window read and advance
        logic load_out;     // move the result into the output register
    } t_wpd_cmd;

    // datapath -> controller
    typedef struct packed {
        logic judge;        // the current item judges a pixel
        logic last_issue;   // the sweep read now issued is the last one
        logic out_free;     // output register can take a result this cycle
    } t_wpd_sts;

endpackage

`default_nettype wire

### rtl/wpd_datapath.sv
// Datapath of the windowed peak detector: configuration registers, pixel
// counter, window ring store, compare logic and output register.
// Depends on wpd_pkg.
`default_nettype none

module wpd_datapath #(
    parameter int PIXELS       = 3648,
    parameter int MAX_DISTANCE = 200
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [wpd_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  wire [wpd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wpd_pkg::t_in                 i_in,
    input  wpd_pkg::t_wpd_cmd            i_cmd,
    output wpd_pkg::t_wpd_sts            o_sts,
    input  wire                          i_out_stall,
    output logic                         o_out_valid,
    output wpd_pkg::t_out                o_out
);
    import wpd_pkg::*;

    localparam int DEPTH = 2 * MAX_DISTANCE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = ((AW > OFF_W) ? AW : OFF_W) + 1;

    logic [THR_W-1:0]  r_thr;
    logic [DIST_W-1:0] r_md;
    logic [PIX_W-1:0]  r_count;
    logic [AW-1:0]     r_ptr;

    logic [DIST_W-1:0] r_d;
    logic              r_judge;
    logic              r_fend;
    logic [PIX_W-1:0]  r_pix;
    logic [AW-1:0]     r_c_idx;
    logic [AW-1:0]     r_j_idx;
    logic [OFF_W-1:0]  r_off;
    logic [OFF_W-1:0]  r_tag_off;
    logic              r_tag_v;
    logic [SMP_W-1:0]  r_center;
    logic              r_peak;
    logic [SMP_W-1:0]  r_rd_data;
    logic              r_out_valid;
    t_out              r_out;

    logic [SMP_W-1:0]  r_mem [DEPTH];

    // accept-time values
    logic [PIX_W-1:0]  n_k;
    logic [AW-1:0]     n_ptr_k;
    logic [DIST_W-1:0] n_d;
    logic [OFF_W-1:0]  n_d2;
    logic [XW-1:0]     n_c_ext;
    logic [XW-1:0]     n_j_ext;
    logic              n_fend;
    logic [AW-1:0]     n_rd_addr;
    logic              n_hit;

    always_comb begin
        n_k     = i_in.frame_start ? '0 : r_count;
        n_ptr_k = i_in.frame_start ? '0 : r_ptr;
        n_d     = (int'(r_md) > MAX_DISTANCE) ? DIST_W'(MAX_DISTANCE) : r_md;
        n_d2    = {n_d, 1'b0};
        // ring index of k-d and k-2d, one wrap correction at most
        if (XW'(n_ptr_k) >= XW'(n_d)) begin
            n_c_ext = XW'(n_ptr_k) - XW'(n_d);
        end else begin
            n_c_ext = XW'(n_ptr_k) + XW'(DEPTH) - XW'(n_d);
        end
        if (XW'(n_ptr_k) >= XW'(n_d2)) begin
            n_j_ext = XW'(n_ptr_k) - XW'(n_d2);
        end else begin
            n_j_ext = XW'(n_ptr_k) + XW'(DEPTH) - XW'(n_d2);
        end
        n_fend    = (n_k == PIX_W'(PIXELS - 1));
        n_rd_addr = i_cmd.rd_center ? r_c_idx : r_j_idx;
        // a window sample other than the judged pixel that reaches its value
        n_hit     = r_tag_v && (r_tag_off != {1'b0, r_d}) && (r_rd_data >= r_center);
    end

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_md    <= DIST_RESET;
            r_count <= '0;
            r_ptr   <= '0;
            r_tag_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD:    r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_MIN_DISTANCE: r_md  <= i_cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_count <= n_fend ? '0 : n_k + PIX_W'(1);
                r_ptr   <= (n_fend || n_ptr_k == AW'(DEPTH - 1)) ? '0
                                                                : n_ptr_k + AW'(1);
            end
            r_tag_v <= i_cmd.sweep;
        end
    end

    // window store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[n_ptr_k] <= i_in.sample;
        end
        if (i_cmd.rd_center || i_cmd.sweep) begin
            r_rd_data <= r_mem[n_rd_addr];
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_d     <= n_d;
            r_judge <= (n_k >= PIX_W'(n_d2));
            r_fend  <= n_fend;
            r_pix   <= n_k - PIX_W'(n_d);
            r_c_idx <= n_c_ext[AW-1:0];
            r_j_idx <= n_j_ext[AW-1:0];
            r_off   <= '0;
        end
        if (i_cmd.load_center) begin
            r_center <= r_rd_data;
            r_peak   <= ({1'b0, r_rd_data} >= r_thr);
        end else if (n_hit) begin
            r_peak <= 1'b0;
        end
        if (i_cmd.sweep) begin
            r_j_idx   <= (r_j_idx == AW'(DEPTH - 1)) ? '0 : r_j_idx + AW'(1);
            r_off     <= r_off + OFF_W'(1);
            r_tag_off <= r_off;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.is_peak        <= r_judge & r_peak;
            r_out.peak_pixel     <= r_judge ? r_pix : '0;
            r_out.peak_intensity <= r_judge ? r_center : '0;
            r_out.frame_end      <= r_fend;
        end
    end

    assign o_sts.judge      = r_judge;
    assign o_sts.last_issue = (r_off == {r_d, 1'b0});
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out            = r_out;

endmodule

`default_nettype wire

### rtl/wpd_ctrl.sv
// Controller of the windowed peak detector: sequences accept, center read,
// window sweep and result hand-off. Depends on wpd_pkg.
`default_nettype none

module wpd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wpd_pkg::t_wpd_sts    i_sts,
    output wpd_pkg::t_wpd_cmd    o_cmd
);
    import wpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_VAL,
        S_SWEEP,
        S_LAST,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CENTER;
                end
            end
            S_CENTER: begin
                if (i_sts.judge) begin
                    o_cmd.rd_center = 1'b1;
                    n_state         = S_VAL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_VAL: begin
                o_cmd.load_center = 1'b1;
                n_state           = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // last window sample is compared on this edge
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

`default_nettype wire

### rtl/windowed_peak_detector_top.sv
// Top level of the windowed peak detector: joins controller and datapath.
// Depends on wpd_pkg, wpd_ctrl, wpd_datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   input    | i_in_valid / o_in_stall  | i_in  (sample, frame_start)
//   output   | o_out_valid / i_out_stall| o_out (is_peak, peak_pixel,
//            |                          |        peak_intensity, frame_end)
//   config   | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// For an item whose pixel is judged, the sweep reads a window of 2*d + 1
// samples (d = min_distance, saturated at MAX_DISTANCE): the window store has
// one read port and the sweep reads one window sample per cycle.
// An item that judges no pixel skips the center read and the sweep.
// The output register lets the next item be accepted while a result waits;
// a stalled output holds only the final hand-off of the following item.
// Reset is synchronous; the window store is not cleared.
`default_nettype none

module windowed_peak_detector_top #(
    parameter int PIXELS       = 3648,
    parameter int MAX_DISTANCE = 200
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [wpd_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  wire [wpd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wpd_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output wpd_pkg::t_out                o_out
);
    import wpd_pkg::*;

    t_wpd_cmd w_cmd;
    t_wpd_sts w_sts;

    wpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wpd_datapath #(
        .PIXELS       (PIXELS),
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### bench/tb_windowed_peak_detector_top.sv
// Testbench for windowed_peak_detector_top: directed and random spectrum frames,
// every result checked against an in-bench prediction of the peak judgement.
// Depends on wpd_pkg and the RTL of the windowed peak detector.
`default_nettype none

module tb_windowed_peak_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpd_pkg::*;

    localparam int PIXELS      = 3648;
    localparam int MAX_DIST    = 200;
    localparam int WIN_DEPTH   = 2 * MAX_DIST + 1;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CIDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in                 i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out                o_out;

    windowed_peak_detector_top #(
        .PIXELS      (PIXELS),
        .MAX_DISTANCE(MAX_DIST)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block: window samples, pixel position, registers
    logic [SMP_W-1:0]  win_samples [0:WIN_DEPTH-1];
    int unsigned       next_pixel  = 0;
    logic [THR_W-1:0]  thr_shadow  = THR_RESET;
    logic [DIST_W-1:0] dist_shadow = DIST_RESET;

    t_out              pending_results [$];
    logic [SMP_W-1:0]  prev_sample = '0;
    bit                send_idles  = 1'b1;
    bit                recv_stalls = 1'b1;
    int unsigned       mismatches  = 0;
    int unsigned       cycle_count = 0;

    // Store the sample at its position and judge pixel k - d.
    function automatic t_out judge_pixel(input t_in item);
        int unsigned k, d, c, v, j;
        logic        hit;
        t_out        r;
        r = '0;
        k = item.frame_start ? 0 : next_pixel;
        if (k >= PIXELS)
            k = 0;
        d = (dist_shadow > MAX_DIST) ? MAX_DIST : dist_shadow;
        win_samples[k % WIN_DEPTH] = item.sample;
        if (k >= 2 * d && k < PIXELS) begin
            c   = k - d;
            v   = win_samples[c % WIN_DEPTH];
            hit = (v >= thr_shadow);
            for (j = c - d; j <= c + d; j++) begin
                if (j != c && win_samples[j % WIN_DEPTH] >= v)
                    hit = 1'b0;
            end
            r.is_peak        = hit;
            r.peak_pixel     = c[PIX_W-1:0];
            r.peak_intensity = v[SMP_W-1:0];
        end
        r.frame_end = (k == PIXELS - 1);
        next_pixel  = r.frame_end ? 0 : ((k + 1) & 12'hFFF);
        return r;
    endfunction

    // Baseline with spikes, plateaus and slopes.
    function automatic logic [SMP_W-1:0] spectrum_sample();
        int unsigned      sel;
        logic [SMP_W-1:0] s;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            s = SMP_W'($urandom_range(0, 300));
        else if (sel < 65)
            s = SMP_W'($urandom_range(0, 4095));
        else if (sel < 77)
            s = prev_sample;
        else if (sel < 88)
            s = SMP_W'($urandom_range(3800, 4095));
        else
            s = prev_sample + SMP_W'($urandom_range(0, 60));
        return s;
    endfunction

    function automatic int unsigned pick_threshold();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)      return 0;
        else if (sel < 20) return 4095;
        else if (sel < 25) return 4096;
        else if (sel < 28) return 8191;
        else if (sel < 75) return $urandom_range(0, 1500);
        else               return $urandom_range(0, 4096);
    endfunction

    // Upper data bits beyond the register width carry junk.
    function automatic int unsigned pick_distance();
        int unsigned sel, d;
        sel = $urandom_range(0, 99);
        if (sel < 12)      d = 0;
        else if (sel < 70) d = $urandom_range(1, 8);
        else if (sel < 88) d = $urandom_range(9, 40);
        else               d = $urandom_range(201, 255);
        return d | ($urandom_range(0, 31) << DIST_W);
    endfunction

    task automatic send_item(input logic [SMP_W-1:0] smp, input logic fs);
        t_in  item;
        t_out exp_res;
        item.sample      = smp;
        item.frame_start = fs;
        @(negedge i_clk);
        while (send_idles && $urandom_range(0, 99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = item;
        i_in_valid = 1'b1;
        exp_res    = judge_pixel(item);
        pending_results.insert(pending_results.size(), exp_res);
        prev_sample = smp;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_W-1:0];
        if (idx == CFG_THRESHOLD)
            thr_shadow = val[THR_W-1:0];
        else
            dist_shadow = val[DIST_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Registers at their reset values: one frame of 60 pixels.
    task automatic test_reset_config();
        int unsigned n;
        for (n = 0; n < 60; n++)
            send_item(spectrum_sample(), n == 0);
        wait_drained();
    endtask

    task automatic test_directed_peaks();
        // d = 1: strict peak, plateau, threshold edge, sample extremes, restart
        write_reg(CFG_THRESHOLD, 100);
        write_reg(CFG_MIN_DISTANCE, 1);
        send_item(12'd50, 1'b1);
        send_item(12'd200, 1'b0);
        send_item(12'd50, 1'b0);
        send_item(12'd200, 1'b0);
        send_item(12'd200, 1'b0);
        send_item(12'd50, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd100, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd99, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd3000, 1'b1);
        send_item(12'd3001, 1'b0);
        wait_drained();
        // d = 0: window is the pixel alone
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_MIN_DISTANCE, 0);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b0);
        wait_drained();
        write_reg(CFG_THRESHOLD, 4096);
        send_item(12'd4095, 1'b0);
        wait_drained();
        write_reg(CFG_THRESHOLD, 4095);
        send_item(12'd4095, 1'b0);
        send_item(12'd4094, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned phase, n, flen, pos;
        logic        fs;
        for (phase = 0; phase < 10; phase++) begin
            wait_drained();
            send_idles  = (phase != 3);
            recv_stalls = (phase != 3);
            write_reg(CFG_THRESHOLD, pick_threshold());
            write_reg(CFG_MIN_DISTANCE, pick_distance());
            n = 0;
            while (n < 43) begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5)
                                                   : $urandom_range(10, 100);
                for (pos = 0; pos < flen && n < 43; pos++) begin
                    if (pos == 0)
                        fs = ($urandom_range(0, 9) != 0);
                    else
                        fs = ($urandom_range(0, 49) == 0);
                    send_item(spectrum_sample(), fs);
                    n++;
                    if (phase == 6 && n == 40)
                        wait_drained();
                end
            end
        end
        send_idles  = 1'b1;
        recv_stalls = 1'b1;
        wait_drained();
    endtask

    // Full window at d = 200, then a saturated distance in the same frame.
    task automatic test_wide_window();
        int unsigned n;
        write_reg(CFG_THRESHOLD, $urandom_range(0, 3000));
        write_reg(CFG_MIN_DISTANCE, MAX_DIST);
        for (n = 0; n < 410; n++)
            send_item(spectrum_sample(), n == 0);
        wait_drained();
        write_reg(CFG_MIN_DISTANCE, 255 | ($urandom_range(1, 31) << DIST_W));
        for (n = 0; n < 30; n++)
            send_item(spectrum_sample(), 1'b0);
        wait_drained();
    endtask

    always @(negedge i_clk)
        i_out_stall <= recv_stalls && ($urandom_range(0, 99) < 17);

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: peak=%0b pix=%0d int=%0d end=%0b",
                             o_out.is_peak, o_out.peak_pixel, o_out.peak_intensity,
                             o_out.frame_end);
            end else begin
                want = pending_results.pop_front();
                if (o_out.is_peak !== want.is_peak ||
                    o_out.peak_pixel !== want.peak_pixel ||
                    o_out.peak_intensity !== want.peak_intensity ||
                    o_out.frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp peak=%0b pix=%0d int=%0d end=%0b,",
                                  " got peak=%0b pix=%0d int=%0d end=%0b"},
                                 want.is_peak, want.peak_pixel, want.peak_intensity,
                                 want.frame_end, o_out.is_peak, o_out.peak_pixel,
                                 o_out.peak_intensity, o_out.frame_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** windowed_peak_detector_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_config();
        test_directed_peaks();
        test_random_frames();
        test_wide_window();
        wait_drained();
        repeat (2 * MAX_DIST + 16) @(posedge i_clk);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** windowed_peak_detector_top: PASSED **");
        end else begin
            $display("** windowed_peak_detector_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
